// File: src/round_robin_pending_signal_table_assert.svh
// ----------------------------------------------------------------------------
// round_robin_pending_signal_table_assert.svh
// Assertion macros for the pending signal table, sampled on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_PENDING_SIGNAL_TABLE_ASSERT_SVH
`define ROUND_ROBIN_PENDING_SIGNAL_TABLE_ASSERT_SVH

// same-cycle implication
`define RRPST_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rrpst assertion failed");

// next-cycle implication
`define RRPST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rrpst assertion failed");

`endif

// File: src/rrpst_pkg.sv
// ----------------------------------------------------------------------------
// rrpst_pkg
// Shared types and constants of the round-robin pending signal table
// ----------------------------------------------------------------------------
`default_nettype none

package rrpst_pkg;

	// default slot count
	localparam int NUM_SLOTS_DEF = 8;

	// fixed field widths
	localparam int IDX_W     = 3;
	localparam int PAYLOAD_W = 32;

	// command codes
	localparam logic CMD_EMIT  = 1'b0;
	localparam logic CMD_PROBE = 1'b1;

	// one input transfer
	typedef struct packed {
		logic                 cmd;
		logic [IDX_W-1:0]     slot_index;
		logic [PAYLOAD_W-1:0] payload;
	} in_item_t;

	// one result transfer
	typedef struct packed {
		logic                 found;
		logic [IDX_W-1:0]     found_index;
		logic [PAYLOAD_W-1:0] found_payload;
	} out_item_t;

	// sequencer status
	typedef struct packed {
		logic scanning;
		logic reading;
	} ctrl_stat_t;

endpackage

`default_nettype wire

// File: src/round_robin_pending_signal_table.sv
// ----------------------------------------------------------------------------
// round_robin_pending_signal_table
// Slot table of pending signals with round-robin probe service
// ----------------------------------------------------------------------------
// Usage:
//   An item transfers at a rising edge with start high and busy low. An emit
//   (cmd 0) writes payload into slot slot_index in that same edge; a zero
//   payload empties the slot and an index beyond the table is dropped. An
//   emit gives no result and leaves busy low, so one can follow every cycle.
//   A probe (cmd 1) gives exactly one result, shown on result for one cycle
//   with done high. When no slot is pending the result (found clear) comes
//   the cycle after the transfer. Otherwise the sequencer walks the pending
//   bits one slot per cycle from the saved pointer, then reads the payload
//   memory through its registered read port and shows the result, with busy
//   high from the transfer until done. The time to done is set by the scan
//   step and the registered memory read.
//   The receiver cannot stall; a result is taken in the cycle it is shown.
//   Reset marks every slot empty and sets the pointer to slot 0.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_pending_signal_table #(
	parameter int NUM_SLOTS = rrpst_pkg::NUM_SLOTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire rrpst_pkg::in_item_t item,
	output logic                     busy,
	output logic                     done,
	output rrpst_pkg::out_item_t     result
);

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic                            wr_en;
	logic [SW-1:0]                   wr_addr;
	logic                            rd_en;
	logic [SW-1:0]                   rd_addr;
	logic [rrpst_pkg::PAYLOAD_W-1:0] rd_data;
	rrpst_pkg::ctrl_stat_t           stat;

	// sequencer
	rrpst_ctrl #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.stat   (stat)
	);

	// payload memory
	rrpst_mem #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(item.payload),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// checks
`include "round_robin_pending_signal_table_assert.svh"

	`RRPST_ASSERT_IMP(a_miss_is_zero, done && !result.found, (result.found_index == '0) && (result.found_payload == '0))
	`RRPST_ASSERT_IMP(a_hit_nonzero, done && result.found, result.found_payload != '0)
	`RRPST_ASSERT_NEXT(a_read_gives_done, stat.reading, done)
	`RRPST_ASSERT_NEXT(a_emit_silent, start && !busy && (item.cmd == rrpst_pkg::CMD_EMIT), !busy && !done)

endmodule

`default_nettype wire

// File: src/rrpst_mem.sv
// ----------------------------------------------------------------------------
// rrpst_mem
// Slot payload memory: one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rrpst_mem #(
	parameter int NUM_SLOTS = rrpst_pkg::NUM_SLOTS_DEF,
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  wire logic                           clk,
	input  wire logic                           wr_en,
	input  wire logic [SW-1:0]                  wr_addr,
	input  wire logic [rrpst_pkg::PAYLOAD_W-1:0] wr_data,
	input  wire logic                           rd_en,
	input  wire logic [SW-1:0]                  rd_addr,
	output logic      [rrpst_pkg::PAYLOAD_W-1:0] rd_data
);

	logic [rrpst_pkg::PAYLOAD_W-1:0] mem [NUM_SLOTS];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: src/rrpst_ctrl.sv
// ----------------------------------------------------------------------------
// rrpst_ctrl
// Command sequencer: pending bits, round-robin pointer and one-slot-per-cycle
// scan that drives the payload memory
// ----------------------------------------------------------------------------
`default_nettype none

module rrpst_ctrl #(
	parameter int NUM_SLOTS = rrpst_pkg::NUM_SLOTS_DEF,
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire rrpst_pkg::in_item_t             item,
	output logic                                 busy,
	output logic                                 done,
	output rrpst_pkg::out_item_t                 result,
	output logic                                 wr_en,
	output logic      [SW-1:0]                   wr_addr,
	output logic                                 rd_en,
	output logic      [SW-1:0]                   rd_addr,
	input  wire logic [rrpst_pkg::PAYLOAD_W-1:0] rd_data,
	output rrpst_pkg::ctrl_stat_t                stat
);

	localparam int IW = (SW > rrpst_pkg::IDX_W) ? SW : rrpst_pkg::IDX_W;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;

	logic [1:0]           state_q;
	logic [NUM_SLOTS-1:0] pending_q;
	logic [SW-1:0]        next_q;
	logic [SW-1:0]        ptr_q;
	logic                 done_q;
	rrpst_pkg::out_item_t result_q;

	logic          accept;
	logic          is_emit;
	logic [IW-1:0] idx_w;
	logic          idx_ok;
	logic [SW-1:0] ptr_inc;
	logic          hit;

	// input decode
	assign accept  = start && (state_q == ST_IDLE);
	assign is_emit = (item.cmd == rrpst_pkg::CMD_EMIT);
	assign idx_w   = IW'(item.slot_index);
	assign idx_ok  = int'(idx_w) < NUM_SLOTS;

	// pointer step with wrap
	assign ptr_inc = (ptr_q == SW'(NUM_SLOTS - 1)) ? '0 : ptr_q + 1'b1;
	assign hit     = pending_q[ptr_q];

	// memory control
	assign wr_en   = accept && is_emit && idx_ok;
	assign wr_addr = SW'(idx_w);
	assign rd_en   = (state_q == ST_SCAN) && hit;
	assign rd_addr = ptr_q;

	// status and outputs
	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign result        = result_q;
	assign stat.scanning = (state_q == ST_SCAN);
	assign stat.reading  = (state_q == ST_READ);

	// sequencer and pending bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pending_q <= '0;
			next_q    <= '0;
			ptr_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_emit) begin
							if (idx_ok) begin
								pending_q[SW'(idx_w)] <= |item.payload;
							end
						end else if (pending_q == '0) begin
							done_q <= 1'b1;
						end else begin
							ptr_q   <= next_q;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						state_q <= ST_READ;
					end else begin
						ptr_q <= ptr_inc;
					end
				end
				ST_READ: begin
					pending_q[ptr_q] <= 1'b0;
					next_q           <= ptr_inc;
					done_q           <= 1'b1;
					state_q          <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept && !is_emit && (pending_q == '0)) begin
			result_q <= '0;
		end else if (state_q == ST_READ) begin
			result_q.found         <= 1'b1;
			result_q.found_index   <= rrpst_pkg::IDX_W'(ptr_q);
			result_q.found_payload <= rd_data;
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the round-robin pending signal table: emit and
// probe commands go through the start/busy handshake, a shadow copy of the
// slot table predicts every probe result, and each done strobe is compared
// field by field against the oldest outstanding prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

	localparam int NUM_SLOTS   = rrpst_pkg::NUM_SLOTS_DEF;
	localparam int DRAIN_LIMIT = 2000;

	logic                 clk    = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start  = 1'b0;
	rrpst_pkg::in_item_t  item   = '0;
	logic                 busy;
	logic                 done;
	rrpst_pkg::out_item_t result;

	// shadow of the slot table and the round-robin pointer
	logic [rrpst_pkg::PAYLOAD_W-1:0] slot_shadow [NUM_SLOTS];
	int                              next_shadow;

	// probe results still owed by the block, oldest first
	rrpst_pkg::out_item_t            probe_expect_q [$];

	int unsigned          fail_count;
	int unsigned          items_sent;
	bit                   idle_enable;

	round_robin_pending_signal_table #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// serve the first pending slot from the pointer on, clearing it
	function automatic rrpst_pkg::out_item_t serve_next_pending();
		rrpst_pkg::out_item_t served;
		int                   s;
		served = '0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			s = (next_shadow + k) % NUM_SLOTS;
			if (slot_shadow[s] != '0) begin
				served.found         = 1'b1;
				served.found_index   = s[rrpst_pkg::IDX_W-1:0];
				served.found_payload = slot_shadow[s];
				slot_shadow[s]       = '0;
				next_shadow          = (s + 1 == NUM_SLOTS) ? 0 : s + 1;
				return served;
			end
		end
		return served;
	endfunction

	// mostly full-range values, with zeros and small values mixed in
	function automatic logic [rrpst_pkg::PAYLOAD_W-1:0] rand_payload();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			return '0;
		else if (pick < 30)
			return rrpst_pkg::PAYLOAD_W'($urandom_range(1, 15));
		else
			return rrpst_pkg::PAYLOAD_W'($urandom);
	endfunction

	// one command transfer, with an optional idle gap ahead of it
	task automatic transfer(input rrpst_pkg::in_item_t cmd_item);
		int unsigned gap;
		if (idle_enable && $urandom_range(0, 99) < 24) begin
			gap = $urandom_range(1, 3);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= cmd_item;
		do @(posedge clk); while (busy);
		// transfer done at this edge: update the shadow table
		if (cmd_item.cmd == rrpst_pkg::CMD_PROBE)
			probe_expect_q.push_back(serve_next_pending());
		else if (cmd_item.slot_index < NUM_SLOTS)
			slot_shadow[cmd_item.slot_index] = cmd_item.payload;
		items_sent++;
	endtask

	task automatic emit_to(input int slot, input logic [rrpst_pkg::PAYLOAD_W-1:0] value);
		rrpst_pkg::in_item_t cmd_item;
		cmd_item.cmd        = rrpst_pkg::CMD_EMIT;
		cmd_item.slot_index = slot[rrpst_pkg::IDX_W-1:0];
		cmd_item.payload    = value;
		transfer(cmd_item);
	endtask

	// index and payload are don't-care for a probe, so keep them random
	task automatic probe_any();
		rrpst_pkg::in_item_t cmd_item;
		cmd_item.cmd        = rrpst_pkg::CMD_PROBE;
		cmd_item.slot_index = rrpst_pkg::IDX_W'($urandom_range(0, 7));
		cmd_item.payload    = rrpst_pkg::PAYLOAD_W'($urandom);
		transfer(cmd_item);
	endtask

	// probe with an empty table, then a slot at each end of the table
	task automatic test_empty_and_wrap();
		probe_any();
		emit_to(NUM_SLOTS - 1, 32'hFFFF_FFFF);
		emit_to(0, 32'h0000_0001);
		probe_any();
		probe_any();
		probe_any();
	endtask

	// overwrite of a pending slot and clearing by a zero payload
	task automatic test_overwrite_clear();
		emit_to(3, 32'h0000_0005);
		emit_to(3, 32'hA5A5_A5A5);
		emit_to(5, 32'h8000_0000);
		emit_to(5, 32'h0000_0000);
		probe_any();
		probe_any();
	endtask

	// full table drained in round-robin order from a mid-table pointer
	task automatic test_full_rotation();
		for (int s = 0; s < NUM_SLOTS; s++)
			emit_to(s, 32'h5A5A_0000 | s);
		for (int s = 0; s < NUM_SLOTS; s++)
			probe_any();
	endtask

	// command after command with no idle gaps at all
	task automatic test_back_to_back();
		idle_enable = 1'b0;
		for (int n = 0; n < 40; n++) begin
			emit_to($urandom_range(0, NUM_SLOTS - 1), rand_payload());
			emit_to($urandom_range(0, NUM_SLOTS - 1), rand_payload());
			probe_any();
		end
		idle_enable = 1'b1;
	endtask

	// bursts of emits followed by probes, with stray single commands between
	task automatic test_random_mix(input int unsigned n_items);
		int unsigned         target;
		rrpst_pkg::in_item_t stray;
		target = items_sent + n_items;
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < 75) begin
				repeat ($urandom_range(1, 4))
					emit_to($urandom_range(0, NUM_SLOTS - 1), rand_payload());
				repeat ($urandom_range(1, 3))
					probe_any();
			end else begin
				stray.cmd        = $urandom_range(0, 1) ? rrpst_pkg::CMD_PROBE
				                                        : rrpst_pkg::CMD_EMIT;
				stray.slot_index = rrpst_pkg::IDX_W'($urandom_range(0, 7));
				stray.payload    = rand_payload();
				transfer(stray);
			end
		end
	endtask

	// compare each result strobe against the oldest prediction
	always @(posedge clk) begin : check_results
		rrpst_pkg::out_item_t want;
		if (arst_n && done) begin
			if (probe_expect_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, result);
				fail_count++;
			end else begin
				want = probe_expect_q.pop_front();
				if (result.found !== want.found) begin
					$display("%0t: found mismatch, expected %0d, actual %0d",
						$time, want.found, result.found);
					fail_count++;
				end
				if (result.found_index !== want.found_index) begin
					$display("%0t: found_index mismatch, expected %0d, actual %0d",
						$time, want.found_index, result.found_index);
					fail_count++;
				end
				if (result.found_payload !== want.found_payload) begin
					$display("%0t: found_payload mismatch, expected %h, actual %h",
						$time, want.found_payload, result.found_payload);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int unsigned wait_cycles;
		for (int s = 0; s < NUM_SLOTS; s++)
			slot_shadow[s] = '0;
		next_shadow = 0;
		fail_count  = 0;
		items_sent  = 0;
		idle_enable = 1'b1;

		// hold reset, then release it
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_wrap();
		test_overwrite_clear();
		test_full_rotation();
		test_back_to_back();
		test_random_mix(1350);

		// no more commands; let outstanding probes finish
		start <= 1'b0;
		wait_cycles = 0;
		while (probe_expect_q.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (NUM_SLOTS + 4) @(posedge clk);

		while (probe_expect_q.size() != 0) begin
			$display("%0t: missing result, expected %h, actual none",
				$time, probe_expect_q.pop_front());
			fail_count++;
		end

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/rrpst_pkg.sv
src/rrpst_mem.sv
src/rrpst_ctrl.sv
src/round_robin_pending_signal_table.sv
tb/sv/tb_top.sv
